FILE: rtl/core/dnsd_pkg.sv
`default_nettype none

package dnsd_pkg;

  // Default name window parameter: at most NAME_BYTES - 1 bytes are examined after the header.
  localparam int NAME_BYTES_DEF = 128;

  // DNS framing constants.
  localparam logic [15:0] HDR_BYTES = 16'd12;
  localparam logic [15:0] MIN_LEN   = 16'd17;
  localparam logic [15:0] MAX_LEN   = 16'd512;
  localparam logic [7:0]  MAX_LABEL = 8'd63;
  localparam logic [7:0]  DOT_CHAR  = 8'h2E;
  localparam logic [15:0] POS_MAX   = 16'hFFFF;

  // Label decoder phase.
  typedef enum logic [1:0] {
    PH_LEN   = 2'd0,
    PH_LABEL = 2'd1,
    PH_STOP  = 2'd2
  } phase_t;

  // One result item as held in the output buffer.
  typedef struct packed {
    logic [7:0] name_char;
    logic       name_done;
    logic [6:0] name_length;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/dnsd_if.sv
`default_nettype none

// Input channel: one payload byte with its packet framing.
interface dnsd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        packet_start;
  logic        packet_end;
  logic [15:0] payload_length;

  modport source (output valid, payload_byte, packet_start, packet_end, payload_length,
                  input ready);
  modport sink   (input valid, payload_byte, packet_start, packet_end, payload_length,
                  output ready);
endinterface

// Result channel: one decoded character or the done marker.
interface dnsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_char;
  logic       name_done;
  logic [6:0] name_length;

  modport source (output valid, name_char, name_done, name_length, input ready);
  modport sink   (input valid, name_char, name_done, name_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dns_label_name_decoder_unit.sv
`default_nettype none

// Channel   Direction  Payload
// in_ch     sink       payload_byte[7:0], packet_start, packet_end, payload_length[15:0]
// out_ch    source     name_char[7:0], name_done, name_length[6:0]
//
// One input item is taken per cycle while in_ch.ready is high; the decoder state updates at
// the accepting edge. An item yields up to two result items, which go into a three-entry
// output buffer that drains one item per cycle while out_ch.ready is high; an item with a
// character and the done marker puts two items in it. in_ch.ready is high while the
// buffer holds at most one item, so it comes straight from a register. Reset (rst_n low,
// synchronous) empties the buffer and clears the decoder. Stalls on out_ch hold the buffer.

module dns_label_name_decoder_unit
  import dnsd_pkg::*;
#(
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  dnsd_in_if.sink      in_ch,
  dnsd_out_if.source   out_ch
);

  localparam int CW = $clog2(NAME_BYTES);
  localparam logic [CW-1:0] CAP = CW'(NAME_BYTES - 1);

  // Decoder state.
  logic [15:0]   pos_r, pos_nxt;
  logic [CW-1:0] limit_r, limit_nxt;
  logic          lv_r, lv_nxt;
  phase_t        phase_r, phase_nxt;
  logic [5:0]    remain_r, remain_nxt;
  logic [CW-1:0] chars_r, chars_nxt;

  // Output buffer.
  result_t       buf_r [3];
  result_t       buf_nxt [3];
  logic [1:0]    count_r, count_nxt;

  logic          accept;
  logic          pop;

  // State as seen by this item, after a packet start restarts it.
  logic [15:0]   pos_s;
  logic [CW-1:0] limit_s;
  logic          lv_s;
  phase_t        phase_s;
  logic [5:0]    remain_s;
  logic [CW-1:0] chars_s;
  logic [15:0]   body_len;
  logic          len_ok;
  logic          in_win;
  logic          at_cap;

  // Results of this item.
  logic          char_vld;
  logic [7:0]    char_val;
  logic [CW-1:0] chars_upd;
  result_t       res0, res1;
  logic [1:0]    n_res;

  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = (count_r != 2'd0) && out_ch.ready;

  // Packet start re-latches the length and clears the decoder.
  assign len_ok   = (in_ch.payload_length >= MIN_LEN) && (in_ch.payload_length <= MAX_LEN);
  assign body_len = in_ch.payload_length - HDR_BYTES;

  always_comb begin
    if (in_ch.packet_start) begin
      pos_s    = 16'd0;
      lv_s     = len_ok;
      if (!len_ok) begin
        limit_s = '0;
      end else if (body_len > 16'(CAP)) begin
        limit_s = CAP;
      end else begin
        limit_s = body_len[CW-1:0];
      end
      phase_s  = PH_LEN;
      remain_s = 6'd0;
      chars_s  = '0;
    end else begin
      pos_s    = pos_r;
      lv_s     = lv_r;
      limit_s  = limit_r;
      phase_s  = phase_r;
      remain_s = remain_r;
      chars_s  = chars_r;
    end
  end

  // The byte lies in the name window past the header.
  assign in_win = lv_s && (pos_s >= HDR_BYTES) && ((pos_s - HDR_BYTES) < 16'(limit_s));
  assign at_cap = (chars_s >= CAP);

  // Next state of the label decoder.
  always_comb begin
    phase_nxt  = phase_s;
    remain_nxt = remain_s;
    chars_nxt  = chars_s;
    lv_nxt     = lv_s;
    limit_nxt  = limit_s;
    pos_nxt    = (pos_s == POS_MAX) ? pos_s : pos_s + 16'd1;
    if (in_win) begin
      unique case (phase_s)
        PH_LEN: begin
          if ((in_ch.payload_byte == 8'd0) || (in_ch.payload_byte > MAX_LABEL) || at_cap) begin
            phase_nxt = PH_STOP;
          end else begin
            if (chars_s != '0) begin
              chars_nxt = chars_s + CW'(1);
            end
            remain_nxt = in_ch.payload_byte[5:0];
            phase_nxt  = PH_LABEL;
          end
        end
        PH_LABEL: begin
          if (at_cap) begin
            phase_nxt = PH_STOP;
          end else begin
            chars_nxt  = chars_s + CW'(1);
            remain_nxt = remain_s - 6'd1;
            if (remain_s == 6'd1) begin
              phase_nxt = PH_LEN;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (in_ch.packet_end) begin
      phase_nxt  = PH_STOP;
      lv_nxt     = 1'b0;
      remain_nxt = 6'd0;
      chars_nxt  = '0;
    end
  end

  // Result items of the decoder: a dot or label byte, then the done marker.
  always_comb begin
    char_vld  = 1'b0;
    char_val  = in_ch.payload_byte;
    chars_upd = chars_s;
    if (in_win) begin
      unique case (phase_s)
        PH_LEN: begin
          if ((in_ch.payload_byte != 8'd0) && (in_ch.payload_byte <= MAX_LABEL) && !at_cap
              && (chars_s != '0)) begin
            char_vld  = 1'b1;
            char_val  = DOT_CHAR;
            chars_upd = chars_s + CW'(1);
          end
        end
        PH_LABEL: begin
          if (!at_cap) begin
            char_vld  = 1'b1;
            chars_upd = chars_s + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Lengths are reported modulo 128.
  logic [CW+6:0] len_wide;
  assign len_wide = {7'd0, chars_upd};

  always_comb begin
    res1.name_char   = 8'd0;
    res1.name_done   = 1'b1;
    res1.name_length = len_wide[6:0];
    if (char_vld) begin
      res0.name_char   = char_val;
      res0.name_done   = 1'b0;
      res0.name_length = len_wide[6:0];
    end else begin
      res0 = res1;
    end
    n_res = {1'b0, char_vld} + {1'b0, in_ch.packet_end};
  end

  // Output buffer: shift out at the head, append behind the remaining items.
  always_comb begin
    result_t    shf [3];
    logic [1:0] base;
    logic [1:0] n_push;
    shf[0] = pop ? buf_r[1] : buf_r[0];
    shf[1] = pop ? buf_r[2] : buf_r[1];
    shf[2] = buf_r[2];
    base   = count_r - {1'b0, pop};
    n_push = accept ? n_res : 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < base) begin
        buf_nxt[i] = shf[i];
      end else if ((2'(i) == base) && (n_push != 2'd0)) begin
        buf_nxt[i] = res0;
      end else if ((2'(i) == base + 2'd1) && (n_push == 2'd2)) begin
        buf_nxt[i] = res1;
      end else begin
        buf_nxt[i] = shf[i];
      end
    end
    count_nxt = base + n_push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 16'd0;
      limit_r  <= '0;
      lv_r     <= 1'b0;
      phase_r  <= PH_LEN;
      remain_r <= 6'd0;
      chars_r  <= '0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        pos_r    <= pos_nxt;
        limit_r  <= limit_nxt;
        lv_r     <= lv_nxt;
        phase_r  <= phase_nxt;
        remain_r <= remain_nxt;
        chars_r  <= chars_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      buf_r[i] <= buf_nxt[i];
    end
  end

  assign in_ch.ready        = (count_r <= 2'd1);
  assign out_ch.valid       = (count_r != 2'd0);
  assign out_ch.name_char   = buf_r[0].name_char;
  assign out_ch.name_done   = buf_r[0].name_done;
  assign out_ch.name_length = buf_r[0].name_length;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import dnsd_pkg::*;

  localparam int NAME_CAP    = NAME_BYTES_DEF - 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 20;
  localparam int RAND_BYTES  = 1900;

  // One payload byte as offered on the input channel, with driver hints.
  typedef struct {
    logic [7:0]  data;
    bit          start;
    bit          pkt_end;
    logic [15:0] plen;
    bit          drain_first;
    bit          fast;
  } byte_item_t;

  logic clk;
  logic rst_n;

  dnsd_in_if  in_if ();
  dnsd_out_if out_if ();

  dns_label_name_decoder_unit #(
    .NAME_BYTES(NAME_BYTES_DEF)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  byte_item_t byte_queue[$];
  result_t    name_results_due[$];
  logic [7:0] pkt_bytes[$];

  byte_item_t cur_byte;
  int         stim_count = 0;
  int         bytes_taken = 0;
  int         fail_count = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         tx_run = 0;
  int         rx_run = 0;
  int         hold_left = 0;
  int         holds_done = 0;

  // Decoder state as the block should hold it.
  logic [15:0] byte_pos;
  int          scan_lim;
  bit          len_ok;
  phase_t      name_phase;
  int          label_left;
  int          char_count;

  // Clock and the single reset at the start of the run.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // All block inputs start at known values.
  initial begin
    in_if.valid          = 1'b0;
    in_if.payload_byte   = 8'h00;
    in_if.packet_start   = 1'b0;
    in_if.packet_end     = 1'b0;
    in_if.payload_length = 16'h0000;
    out_if.ready         = 1'b0;
  end

  // Queue one expected result item.
  task automatic push_result(input logic [7:0] ch, input logic done);
    result_t r;
    r.name_char   = ch;
    r.name_done   = done;
    r.name_length = 7'(char_count);
    name_results_due.push_back(r);
  endtask

  // Advance the decoder by one accepted byte and queue what it yields.
  task automatic decode_name_byte(input byte_item_t it);
    int at;
    int span;
    if (it.start) begin
      at = 0;
      len_ok = (it.plen >= MIN_LEN) && (it.plen <= MAX_LEN);
      span = int'(it.plen) - int'(HDR_BYTES);
      if (!len_ok) begin
        scan_lim = 0;
      end else if (span > NAME_CAP) begin
        scan_lim = NAME_CAP;
      end else begin
        scan_lim = span;
      end
      name_phase = PH_LEN;
      label_left = 0;
      char_count = 0;
    end else begin
      at = int'(byte_pos);
    end

    // Only bytes inside the name window after the header are decoded.
    if (len_ok && at >= int'(HDR_BYTES) && (at - int'(HDR_BYTES)) < scan_lim) begin
      case (name_phase)
        PH_LEN: begin
          if (it.data == 8'd0 || it.data > MAX_LABEL || char_count >= NAME_CAP) begin
            name_phase = PH_STOP;
          end else begin
            if (char_count > 0) begin
              char_count++;
              push_result(DOT_CHAR, 1'b0);
            end
            label_left = int'(it.data);
            name_phase = PH_LABEL;
          end
        end
        PH_LABEL: begin
          if (char_count >= NAME_CAP) begin
            name_phase = PH_STOP;
          end else begin
            char_count++;
            push_result(it.data, 1'b0);
            label_left = (label_left - 1) & 63;
            if (label_left == 0) name_phase = PH_LEN;
          end
        end
        default: ;
      endcase
    end

    byte_pos = (at < int'(POS_MAX)) ? 16'(at + 1) : POS_MAX;

    // The last byte of a packet closes it with a done item.
    if (it.pkt_end) begin
      push_result(8'h00, 1'b1);
      name_phase = PH_STOP;
      len_ok = 1'b0;
      label_left = 0;
      char_count = 0;
    end
  endtask

  // Wait draw shared by both sides, with occasional runs of no waiting.
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      run_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(97, 122));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_byte(input logic [7:0] d, input bit s, input bit e,
                            input logic [15:0] pl, input bit drain, input bit fast);
    byte_item_t it;
    it.data        = d;
    it.start       = s;
    it.pkt_end     = e;
    it.plen        = pl;
    it.drain_first = drain;
    it.fast        = fast;
    byte_queue.push_back(it);
    if (!fast) stim_count++;
  endtask

  // Send the bytes built in pkt_bytes as one packet.
  task automatic emit_packet(input logic [15:0] pl, input bit has_end, input bit drain);
    int last;
    last = pkt_bytes.size() - 1;
    for (int i = 0; i <= last; i++) begin
      queue_byte(pkt_bytes[i], i == 0, has_end && i == last,
                 (i == 0) ? pl : 16'($urandom), drain && i == 0, 1'b0);
    end
  endtask

  // Build a header, a query name and a question trailer in pkt_bytes.
  task automatic build_query(input bit long_name);
    int nlab;
    int len;
    pkt_bytes.delete();
    repeat (12) pkt_bytes.push_back(8'($urandom));
    nlab = long_name ? 3 : $urandom_range(1, 4);
    for (int l = 0; l < nlab; l++) begin
      if (long_name) begin
        len = (l < 2) ? $urandom_range(60, 63) : $urandom_range(1, 63);
      end else if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(1, 63);
      end else begin
        len = $urandom_range(1, 10);
      end
      pkt_bytes.push_back(8'(len));
      repeat (len) pkt_bytes.push_back(pick_char());
    end
    pkt_bytes.push_back(8'h00);
    repeat (4) pkt_bytes.push_back(8'($urandom));
  endtask

  // A length field that disagrees with the bytes actually sent.
  function automatic logic [15:0] skewed_length(input int size);
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'((size > 8) ? size - $urandom_range(1, 8) : 0);
      2: return 16'(size + $urandom_range(1, 600));
      3: return MIN_LEN - 16'd1;
      4: return MAX_LEN + 16'd1;
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'd0;
          1: return MIN_LEN;
          2: return MAX_LEN;
          default: return POS_MAX;
        endcase
      end
    endcase
  endfunction

  // One random packet or piece of noise.
  task automatic queue_random_packet();
    int kind;
    int cut;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      build_query(1'b0);
      emit_packet(16'(pkt_bytes.size()), 1'b1, $urandom_range(0, 11) == 0);
    end else if (kind < 65) begin
      build_query(1'b1);
      emit_packet(16'(pkt_bytes.size()), 1'b1, 1'b0);
    end else if (kind < 73) begin
      build_query(1'b0);
      emit_packet(skewed_length(pkt_bytes.size()), 1'b1, 1'b0);
    end else if (kind < 80) begin
      // Packet ends early, cut at a random byte.
      build_query(1'b0);
      cut = $urandom_range(1, pkt_bytes.size());
      while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
      emit_packet(16'($urandom_range(17, 80)), 1'b1, 1'b0);
    end else if (kind < 86) begin
      // No end byte: the next packet start interrupts this one.
      build_query(1'b0);
      cut = $urandom_range(1, pkt_bytes.size());
      while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
      emit_packet(16'($urandom_range(17, 80)), 1'b0, 1'b0);
    end else if (kind < 92) begin
      // A zero or oversized label length in the middle of the name.
      pkt_bytes.delete();
      repeat (12) pkt_bytes.push_back(8'($urandom));
      n = $urandom_range(1, 6);
      pkt_bytes.push_back(8'(n));
      repeat (n) pkt_bytes.push_back(pick_char());
      pkt_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(64, 255)));
      repeat ($urandom_range(1, 6)) pkt_bytes.push_back(8'($urandom));
      emit_packet(16'(pkt_bytes.size()), 1'b1, 1'b0);
    end else if (kind < 96) begin
      // Stray bytes outside any packet, maybe with a stray end.
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        queue_byte(8'($urandom), 1'b0, (i == n - 1) && $urandom_range(0, 1),
                   16'($urandom), 1'b0, 1'b0);
      end
    end else begin
      pkt_bytes.delete();
      repeat ($urandom_range(1, 30)) pkt_bytes.push_back(8'($urandom));
      emit_packet(($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 600)),
                  $urandom_range(0, 3) != 0, 1'b0);
    end
  endtask

  // Input driver: offers queued bytes with random gaps between them.
  always @(posedge clk) begin
    bit busy;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      busy = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        decode_name_byte(cur_byte);
        bytes_taken <= bytes_taken + 1;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_queue.size() != 0 &&
                     (!byte_queue[0].drain_first || name_results_due.size() == 0)) begin
          cur_byte = byte_queue.pop_front();
          in_if.payload_byte   <= cur_byte.data;
          in_if.packet_start   <= cur_byte.start;
          in_if.packet_end     <= cur_byte.pkt_end;
          in_if.payload_length <= cur_byte.plen;
          busy = 1'b1;
          gap_left = cur_byte.fast ? 0 : draw_wait(tx_run);
        end
      end
      in_if.valid <= busy;
    end
  end

  // Long receiver hold-offs so the output buffer fills and the input stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && bytes_taken >= 300) ||
                 (holds_done == 1 && bytes_taken >= 1000)) begin
      hold_left <= 250;
      holds_done <= holds_done + 1;
    end
  end

  // Result monitor: checks each accepted item against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (name_results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Unexpected result item: char %02h done %0b length %0d",
                     out_if.name_char, out_if.name_done, out_if.name_length);
          end
        end else begin
          want = name_results_due.pop_front();
          if (out_if.name_char !== want.name_char || out_if.name_done !== want.name_done ||
              out_if.name_length !== want.name_length) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("Mismatch: expected %02h/%0b/%0d, got %02h/%0b/%0d",
                       want.name_char, want.name_done, want.name_length,
                       out_if.name_char, out_if.name_done, out_if.name_length);
            end
          end
        end
        stall_left = draw_wait(rx_run);
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("dns_label_name_decoder_unit verification failed");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    byte_pos   = '0;
    scan_lim   = 0;
    len_ok     = 1'b0;
    name_phase = PH_LEN;
    label_left = 0;
    char_count = 0;

    // Bytes before any packet, a stray end, and one-byte packets.
    queue_byte(8'hFF, 1'b0, 1'b0, 16'hFFFF, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0);
    queue_byte(8'h41, 1'b1, 1'b1, MIN_LEN, 1'b0, 1'b0);
    queue_byte(8'h42, 1'b1, 1'b1, MAX_LEN, 1'b0, 1'b0);
    queue_byte(8'h43, 1'b1, 1'b1, MAX_LEN + 16'd1, 1'b0, 1'b0);

    // Shortest valid query: two labels filling the five-byte window.
    pkt_bytes.delete();
    for (int i = 0; i < 12; i++) pkt_bytes.push_back(i[0] ? 8'hFF : 8'h00);
    pkt_bytes.push_back(8'd1);
    pkt_bytes.push_back(8'h61);
    pkt_bytes.push_back(8'd2);
    pkt_bytes.push_back(8'h62);
    pkt_bytes.push_back(8'h63);
    emit_packet(MIN_LEN, 1'b1, 1'b1);

    while (stim_count < RAND_BYTES + 25) queue_random_packet();

    build_query(1'b0);
    emit_packet(16'(pkt_bytes.size()), 1'b1, 1'b1);

    // Wait for every queued byte to be taken and every result to come out.
    while (bytes_taken < stim_count) @(posedge clk);
    while (name_results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && name_results_due.size() == 0) begin
      $display("dns_label_name_decoder_unit verification clean");
    end else begin
      $display("dns_label_name_decoder_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: dns_label_name_decoder_unit.f
rtl/core/dnsd_pkg.sv
rtl/core/dnsd_if.sv
rtl/core/dns_label_name_decoder_unit.sv
dv/tb_top.sv
